### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hdl/gbd_pkg.sv
package gbd_pkg;

  localparam int unsigned Lanes   = 4;
  localparam int unsigned DoseW   = 2;
  localparam int unsigned CntW    = 17;
  localparam int unsigned SumW    = 18;
  localparam int unsigned QuotW   = 18;
  localparam int unsigned FreqW   = 16;

  localparam logic [DoseW-1:0] DoseMissing = 2'd3;
  localparam logic [CntW-1:0]  CntMax      = '1;
  localparam logic [SumW-1:0]  SumMax      = '1;

  // Largest number of samples one variant may hold.
  localparam int unsigned      MaxSamples  = 65536;
  localparam logic [CntW-1:0]  CountCap    =
      CntW'((MaxSamples > 131071) ? 131071 : MaxSamples);

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [3:0] keep_mask;
  } in_req_t;

  typedef struct packed {
    logic [DoseW-1:0] dosage_lane0;
    logic [DoseW-1:0] dosage_lane1;
    logic [DoseW-1:0] dosage_lane2;
    logic [DoseW-1:0] dosage_lane3;
    logic [Lanes-1:0] lanes_kept;
    logic             variant_done;
    logic             all_missing;
    logic [QuotW-1:0] mean_dosage;
    logic [FreqW-1:0] minor_freq;
    logic [CntW-1:0]  missing_total;
  } out_req_t;

  // Decoded byte plus the counter values after it has been counted.
  typedef struct packed {
    logic [Lanes-1:0][DoseW-1:0] dose;
    logic [Lanes-1:0]            kept;
    logic                        last;
    logic [CntW-1:0]             called;
    logic [CntW-1:0]             missing;
    logic [SumW-1:0]             sum;
  } acc_res_t;

  typedef enum logic [1:0] {
    StIdle,
    StMean,
    StMinor
  } gbd_state_e;

  typedef struct packed {
    logic div_start;
    logic sel_minor;
    logic set_mean;
    logic set_minor;
  } gbd_ctl_t;

  function automatic logic [DoseW-1:0] code_to_dose(input logic [1:0] code);
    logic [DoseW-1:0] d;
    unique case (code)
      2'b00:   d = 2'd2;
      2'b01:   d = DoseMissing;
      2'b10:   d = 2'd1;
      default: d = 2'd0;
    endcase
    return d;
  endfunction

endpackage

### hdl/gbd_accum.sv
module gbd_accum import gbd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  in_req_t         req_i,
  input  logic [CntW-1:0] count_i,
  output acc_res_t        res_o
);

  logic [CntW-1:0]   pos_q, called_q, missing_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW:0]     pos_ext, cnt_ext;
  logic [Lanes-1:0]  in_rng;
  logic [2:0]        called_inc, miss_inc;
  logic [3:0]        dose_inc;
  logic [CntW:0]     called_sum, miss_sum;
  logic [SumW:0]     dose_sum;

  always_comb begin
    pos_ext    = {1'b0, pos_q};
    cnt_ext    = {1'b0, count_i};
    called_inc = '0;
    miss_inc   = '0;
    dose_inc   = '0;
    res_o.last = (pos_ext + (CntW+1)'(Lanes)) >= cnt_ext;
    for (int j = 0; j < Lanes; j++) begin
      in_rng[j]     = (pos_ext + (CntW+1)'(j)) < cnt_ext;
      res_o.kept[j] = in_rng[j] && req_i.keep_mask[j];
      res_o.dose[j] = res_o.kept[j] ? code_to_dose(req_i.packed_byte[2*j +: 2])
                                    : DoseMissing;
      if (res_o.kept[j]) begin
        if (res_o.dose[j] == DoseMissing) begin
          miss_inc = miss_inc + 3'd1;
        end else begin
          called_inc = called_inc + 3'd1;
          dose_inc   = dose_inc + {2'b00, res_o.dose[j]};
        end
      end
    end
    // Adding the whole byte and then clamping equals clamping after each lane.
    called_sum    = {1'b0, called_q} + (CntW+1)'(called_inc);
    miss_sum      = {1'b0, missing_q} + (CntW+1)'(miss_inc);
    dose_sum      = {1'b0, sum_q} + (SumW+1)'(dose_inc);
    res_o.called  = called_sum[CntW] ? CntMax : called_sum[CntW-1:0];
    res_o.missing = miss_sum[CntW] ? CntMax : miss_sum[CntW-1:0];
    res_o.sum     = dose_sum[SumW] ? SumMax : dose_sum[SumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      called_q  <= '0;
      missing_q <= '0;
      sum_q     <= '0;
    end else if (accept_i) begin
      if (res_o.last) begin
        pos_q     <= '0;
        called_q  <= '0;
        missing_q <= '0;
        sum_q     <= '0;
      end else begin
        pos_q     <= pos_q + CntW'(Lanes);
        called_q  <= res_o.called;
        missing_q <= res_o.missing;
        sum_q     <= res_o.sum;
      end
    end
  end

endmodule

### hdl/gbd_div.sv
module gbd_div import gbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CntW-1:0]  dvd_hi_i,
  input  logic [QuotW-1:0] dvd_lo_i,
  input  logic [CntW-1:0]  dvsr_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(QuotW + 1);

  logic [CntW-1:0]  rem_q, rem_d, dvsr_q;
  logic [QuotW-1:0] q_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]    trial, diff;
  logic             ge;

  // One restoring step per cycle; the remainder always stays below the divisor.
  always_comb begin
    trial  = {rem_q, q_q[QuotW-1]};
    diff   = trial - {1'b0, dvsr_q};
    ge     = trial >= {1'b0, dvsr_q};
    rem_d  = ge ? diff[CntW-1:0] : trial[CntW-1:0];
    quot_o = {q_q[QuotW-2:0], ge};
    done_o = (step_q == StepW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepW'(QuotW);
    end else if (step_q != '0) begin
      step_q <= step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dvd_hi_i;
      q_q    <= dvd_lo_i;
      dvsr_q <= dvsr_i;
    end else if (step_q != '0) begin
      rem_q <= rem_d;
      q_q   <= quot_o;
    end
  end

endmodule

### hdl/genotype_byte_decode_maf_core.sv
// A byte that does not end its variant shows its request in the cycle after acceptance.
// A byte that ends a variant with called samples shows its request once the shared divider has run
// 18 steps for the mean and 18 for the minor frequency, and then the output register is loaded.
// Throughput: one byte per cycle inside a variant unless the output stalls; a closing byte with
// called samples holds off input until both divisions are done; one with none needs no division.
// Reset (rst_ni low, asynchronous) clears all counters, sets the sample count (sc_q) to 1, empties output.
module genotype_byte_decode_maf_core import gbd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_req_t         in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_req_t        out_req_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i
);

  gbd_state_e       state_q, state_d;
  gbd_ctl_t         ctl;
  acc_res_t         acc;
  out_req_t         out_q;
  logic             out_valid_q, out_valid_d;
  logic [CntW-1:0]  sc_q, count;
  logic [CntW-1:0]  den_q;
  logic [SumW-1:0]  sum_q, sum_cap, two_den, two_den_q, m_val;
  logic             accept, none_called;
  logic             div_done;
  logic [QuotW-1:0] div_quot;
  logic [CntW-1:0]  div_hi, div_dvsr;
  logic [QuotW-1:0] div_lo;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign none_called = (acc.called == '0);

  always_comb begin
    if (sc_q == '0) begin
      count = CntW'(1);
    end else if (sc_q > CountCap) begin
      count = CountCap;
    end else begin
      count = sc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= CntW'(1);
    end else if (cfg_we_i) begin
      sc_q <= cfg_wdata_i;
    end
  end

  gbd_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .count_i  (count),
    .res_o    (acc)
  );

  // The sum is capped at twice the called count. For the minor frequency,
  // min(sum, 2*den - sum) is chosen, which equals the smaller of the two numerators.
  always_comb begin
    two_den   = {acc.called, 1'b0};
    sum_cap   = (acc.sum > two_den) ? two_den : acc.sum;
    two_den_q = {den_q, 1'b0};
    m_val     = (sum_q <= {1'b0, den_q}) ? sum_q : (two_den_q - sum_q);
    if (ctl.sel_minor) begin
      div_hi   = {2'b00, m_val[SumW-1:3]};
      div_lo   = {m_val[2:0], 15'd0};
      div_dvsr = den_q;
    end else begin
      div_hi   = {1'b0, sum_cap[SumW-1:2]};
      div_lo   = {sum_cap[1:0], 16'd0};
      div_dvsr = acc.called;
    end
  end

  gbd_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctl.div_start),
    .dvd_hi_i (div_hi),
    .dvd_lo_i (div_lo),
    .dvsr_i   (div_dvsr),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && acc.last && !none_called) begin
          state_d = StMean;
        end
      end
      StMean: begin
        if (div_done) begin
          state_d = StMinor;
        end
      end
      StMinor: begin
        if (div_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_q)
      StIdle: begin
        ctl.div_start = accept && acc.last && !none_called;
      end
      StMean: begin
        ctl.sel_minor = 1'b1;
        ctl.div_start = div_done;
        ctl.set_mean  = div_done;
      end
      StMinor: begin
        ctl.sel_minor = 1'b1;
        ctl.set_minor = div_done;
      end
      default: ctl = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept && (!acc.last || none_called)) begin
      out_valid_d = 1'b1;
    end
    if (ctl.set_minor) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.dosage_lane0  <= acc.dose[0];
      out_q.dosage_lane1  <= acc.dose[1];
      out_q.dosage_lane2  <= acc.dose[2];
      out_q.dosage_lane3  <= acc.dose[3];
      out_q.lanes_kept    <= acc.kept;
      out_q.variant_done  <= acc.last;
      out_q.all_missing   <= acc.last && none_called;
      out_q.mean_dosage   <= '0;
      out_q.minor_freq    <= '0;
      out_q.missing_total <= acc.last ? acc.missing : '0;
      den_q               <= acc.called;
      sum_q               <= sum_cap;
    end
    if (ctl.set_mean) begin
      out_q.mean_dosage <= div_quot;
    end
    if (ctl.set_minor) begin
      out_q.minor_freq <= div_quot[FreqW-1:0];
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_plain_byte_no_stats, clk_i, rst_ni,
                  out_valid_o && !out_req_o.variant_done,
                  !out_req_o.all_missing && (out_req_o.mean_dosage == '0) &&
                  (out_req_o.minor_freq == '0) && (out_req_o.missing_total == '0))
  `ASSERT_IMPLIES(a_all_missing_zero, clk_i, rst_ni,
                  out_valid_o && out_req_o.all_missing,
                  out_req_o.variant_done && (out_req_o.mean_dosage == '0) &&
                  (out_req_o.minor_freq == '0))
  `ASSERT_IMPLIES(a_minor_le_half_mean, clk_i, rst_ni,
                  out_valid_o && out_req_o.variant_done,
                  {1'b0, out_req_o.minor_freq, 1'b0} <= out_req_o.mean_dosage)
  `ASSERT_NEXT(a_minor_done_shows, clk_i, rst_ni,
               (state_q == StMinor) && div_done,
               out_valid_o && out_req_o.variant_done && !out_req_o.all_missing)

endmodule
